/* rtl/pwdc_pkg.sv */
// Types, constants and microcode program for the PID controller with dead band and clamps.
package pwdc_pkg;

    localparam int ACC_W  = 66;
    localparam int MUL_W  = 33;
    localparam int PC_W   = 5;
    localparam int CFG_IW = 3;

    localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

    typedef enum logic [CFG_IW-1:0] {
        CFG_KP         = 3'd0,
        CFG_KI         = 3'd1,
        CFG_KD_OVER_DT = 3'd2,
        CFG_STEP_TIME  = 3'd3,
        CFG_DEAD_BAND  = 3'd4,
        CFG_ERR_LIMIT  = 3'd5,
        CFG_INT_LIMIT  = 3'd6,
        CFG_OUT_LIMIT  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_ERR   = 4'd1,
        OP_DBAND = 4'd2,
        OP_CLAMP = 4'd3,
        OP_SAT   = 4'd4,
        OP_MUL   = 4'd5,
        OP_SHIFT = 4'd6,
        OP_ADDI  = 4'd7,
        OP_DIFF  = 4'd8,
        OP_SUM   = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        LIM_ERR = 2'd0,
        LIM_INT = 2'd1,
        LIM_OUT = 2'd2
    } t_lim;

    typedef enum logic [1:0] {
        MUL_E_STEP   = 2'd0,
        MUL_KI_INTEG = 2'd1,
        MUL_KP_E     = 2'd2,
        MUL_KD_DIFF  = 2'd3
    } t_msel;

    typedef enum logic [2:0] {
        DST_NONE  = 3'd0,
        DST_E     = 3'd1,
        DST_INTEG = 3'd2,
        DST_P     = 3'd3,
        DST_I     = 3'd4,
        DST_D     = 3'd5,
        DST_DRIVE = 3'd6
    } t_dst;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_LIM_ZERO = 2'd1,
        COND_END      = 2'd2
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_lim            lim;
        t_msel           msel;
        t_dst            dst;
        t_cond           cond;
        logic            flag_en;
        logic [PC_W-1:0] target;
    } t_ctrl;

    function automatic t_ctrl mk(input t_op op, input t_lim lim, input t_msel msel,
                                 input t_dst dst, input t_cond cond, input logic flag_en,
                                 input logic [PC_W-1:0] target);
        t_ctrl c;
        c.op      = op;
        c.lim     = lim;
        c.msel    = msel;
        c.dst     = dst;
        c.cond    = cond;
        c.flag_en = flag_en;
        c.target  = target;
        return c;
    endfunction

    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        case (pc)
            5'd0: begin c = mk(OP_ERR,   LIM_ERR, MUL_E_STEP,   DST_NONE,  COND_NONE,     1'b0, 5'd0); end
            5'd1: begin c = mk(OP_DBAND, LIM_ERR, MUL_E_STEP,   DST_NONE,  COND_NONE,     1'b0, 5'd0); end
            5'd2: begin c = mk(OP_CLAMP, LIM_ERR, MUL_E_STEP,   DST_NONE,  COND_LIM_ZERO, 1'b0, 5'd3); end
            5'd3: begin c = mk(OP_SAT,   LIM_ERR, MUL_E_STEP,   DST_E,     COND_NONE,     1'b0, 5'd0); end
            5'd4: begin c = mk(OP_MUL,   LIM_ERR, MUL_E_STEP,   DST_NONE,  COND_NONE,     1'b0, 5'd0); end
            5'd5: begin c = mk(OP_SHIFT, LIM_ERR, MUL_E_STEP,   DST_NONE,  COND_NONE,     1'b0, 5'd0); end
            5'd6: begin c = mk(OP_ADDI,  LIM_ERR, MUL_E_STEP,   DST_NONE,  COND_NONE,     1'b0, 5'd0); end
            5'd7: begin c = mk(OP_CLAMP, LIM_INT, MUL_E_STEP,   DST_NONE,  COND_LIM_ZERO, 1'b0, 5'd8); end
            5'd8: begin c = mk(OP_SAT,   LIM_ERR, MUL_E_STEP,   DST_INTEG, COND_NONE,     1'b0, 5'd0); end
            5'd9: begin c = mk(OP_MUL,   LIM_ERR, MUL_KI_INTEG, DST_NONE,  COND_NONE,     1'b0, 5'd0); end
            5'd10: begin c = mk(OP_SHIFT, LIM_ERR, MUL_KI_INTEG, DST_NONE, COND_NONE,     1'b0, 5'd0); end
            5'd11: begin c = mk(OP_SAT,   LIM_ERR, MUL_KI_INTEG, DST_I,    COND_NONE,     1'b1, 5'd0); end
            5'd12: begin c = mk(OP_MUL,   LIM_ERR, MUL_KP_E,     DST_NONE, COND_NONE,     1'b0, 5'd0); end
            5'd13: begin c = mk(OP_SHIFT, LIM_ERR, MUL_KP_E,     DST_NONE, COND_NONE,     1'b0, 5'd0); end
            5'd14: begin c = mk(OP_SAT,   LIM_ERR, MUL_KP_E,     DST_P,    COND_NONE,     1'b1, 5'd0); end
            5'd15: begin c = mk(OP_DIFF,  LIM_ERR, MUL_KD_DIFF,  DST_NONE, COND_NONE,     1'b0, 5'd0); end
            5'd16: begin c = mk(OP_MUL,   LIM_ERR, MUL_KD_DIFF,  DST_NONE, COND_NONE,     1'b0, 5'd0); end
            5'd17: begin c = mk(OP_SHIFT, LIM_ERR, MUL_KD_DIFF,  DST_NONE, COND_NONE,     1'b0, 5'd0); end
            5'd18: begin c = mk(OP_SAT,   LIM_ERR, MUL_KD_DIFF,  DST_D,    COND_NONE,     1'b1, 5'd0); end
            5'd19: begin c = mk(OP_SUM,   LIM_ERR, MUL_KD_DIFF,  DST_NONE, COND_NONE,     1'b0, 5'd0); end
            5'd20: begin c = mk(OP_SAT,   LIM_ERR, MUL_KD_DIFF,  DST_NONE, COND_NONE,     1'b1, 5'd0); end
            5'd21: begin c = mk(OP_CLAMP, LIM_OUT, MUL_KD_DIFF,  DST_DRIVE, COND_END,     1'b1, 5'd0); end
            default: begin c = mk(OP_NOP, LIM_ERR, MUL_E_STEP,   DST_NONE, COND_END,      1'b0, 5'd0); end
        endcase
        return c;
    endfunction

endpackage

/* rtl/pid_with_deadband_and_clamps.sv */
// PID controller step with dead band, symmetric clamps and a microcoded datapath.
// The step program has 22 microcode steps on one shared 33x33 multiplier and one wide
// accumulator. A result is registered at the last step once the output register is free;
// a new word is accepted only when the previous one has finished (o_in_ready is !r_busy).
// A finished result waits in the output register while the next word is accepted.
// Reset (synchronous, active low) restores the register defaults, zeroes integral and
// last measurement, and empties the sequencer and output register.
module pid_with_deadband_and_clamps #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pwdc_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [31:0]             i_target,
    input  logic signed [31:0]             i_measured,
    input  logic signed [31:0]             i_bias,
    input  logic                           i_clear_integral,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [31:0]             o_drive,
    output logic signed [31:0]             o_error_used,
    output logic                           o_drive_clamped
);

    localparam int AW = pwdc_pkg::ACC_W;
    localparam int MW = pwdc_pkg::MUL_W;
    localparam int PW = pwdc_pkg::PC_W;

    logic signed [31:0]    r_kp, r_ki, r_kd;
    logic [16:0]           r_step;
    logic [30:0]           r_dband, r_elim, r_ilim, r_olim;

    logic signed [31:0]    r_integ, n_integ;
    logic signed [31:0]    r_last;
    logic signed [31:0]    r_tgt, r_meas, r_bias;
    logic signed [31:0]    r_e, n_e;
    logic signed [31:0]    r_p, n_p, r_i, n_i, r_d, n_d, r_drv, n_drv;
    logic signed [AW-1:0]  r_acc, n_acc;
    logic signed [AW-1:0]  r_prod, n_prod;
    logic                  r_flag, n_flag;
    logic                  r_busy;
    logic [PW-1:0]         r_pc;
    logic                  r_out_valid;
    logic signed [31:0]    r_out_drive, r_out_err;
    logic                  r_out_clamped;

    pwdc_pkg::t_ctrl       ctrl;
    logic [30:0]           lim;
    logic                  lim_zero;
    logic                  skip;
    logic                  done;
    logic signed [AW-1:0]  lim_pos, lim_neg, db_pos, db_neg;
    logic signed [MW-1:0]  mul_a, mul_b;

    assign ctrl        = pwdc_pkg::ucode(r_pc);
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_drive         = r_out_drive;
    assign o_error_used    = r_out_err;
    assign o_drive_clamped = r_out_clamped;

    always_comb begin
        case (ctrl.lim)
            pwdc_pkg::LIM_ERR: begin lim = r_elim; end
            pwdc_pkg::LIM_INT: begin lim = r_ilim; end
            pwdc_pkg::LIM_OUT: begin lim = r_olim; end
            default:           begin lim = r_olim; end
        endcase
    end

    assign lim_zero = (lim == 31'd0);
    assign lim_pos  = $signed({{(AW-31){1'b0}}, lim});
    assign lim_neg  = -lim_pos;
    assign db_pos   = $signed({{(AW-31){1'b0}}, r_dband});
    assign db_neg   = -db_pos;
    assign skip     = (ctrl.cond == pwdc_pkg::COND_LIM_ZERO) && lim_zero;
    assign done     = r_busy && (ctrl.cond == pwdc_pkg::COND_END)
                      && (!r_out_valid || i_out_ready);

    always_comb begin
        case (ctrl.msel)
            pwdc_pkg::MUL_E_STEP: begin
                mul_a = MW'(r_e);
                mul_b = $signed({{(MW-17){1'b0}}, r_step});
            end
            pwdc_pkg::MUL_KI_INTEG: begin
                mul_a = MW'(r_ki);
                mul_b = MW'(r_integ);
            end
            pwdc_pkg::MUL_KP_E: begin
                mul_a = MW'(r_kp);
                mul_b = MW'(r_e);
            end
            pwdc_pkg::MUL_KD_DIFF: begin
                mul_a = MW'(r_kd);
                mul_b = r_acc[MW-1:0];
            end
            default: begin
                mul_a = MW'(r_kp);
                mul_b = MW'(r_e);
            end
        endcase
    end

    always_comb begin
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_flag  = r_flag;
        n_e     = r_e;
        n_integ = r_integ;
        n_p     = r_p;
        n_i     = r_i;
        n_d     = r_d;
        n_drv   = r_drv;
        if (r_busy && !skip) begin
            case (ctrl.op)
                pwdc_pkg::OP_ERR: begin
                    n_acc = AW'(r_tgt) - AW'(r_meas) + AW'(r_bias);
                end
                pwdc_pkg::OP_DBAND: begin
                    if (r_acc < db_pos && r_acc > db_neg) begin
                        n_acc = '0;
                    end
                end
                pwdc_pkg::OP_CLAMP: begin
                    if (!lim_zero && r_acc > lim_pos) begin
                        n_acc  = lim_pos;
                        n_flag = r_flag | ctrl.flag_en;
                    end else if (!lim_zero && r_acc < lim_neg) begin
                        n_acc  = lim_neg;
                        n_flag = r_flag | ctrl.flag_en;
                    end
                end
                pwdc_pkg::OP_SAT: begin
                    if (r_acc > pwdc_pkg::SAT_MAX) begin
                        n_acc  = pwdc_pkg::SAT_MAX;
                        n_flag = r_flag | ctrl.flag_en;
                    end else if (r_acc < pwdc_pkg::SAT_MIN) begin
                        n_acc  = pwdc_pkg::SAT_MIN;
                        n_flag = r_flag | ctrl.flag_en;
                    end
                end
                pwdc_pkg::OP_MUL: begin
                    n_prod = AW'(mul_a * mul_b);
                end
                pwdc_pkg::OP_SHIFT: begin
                    n_acc = r_prod >>> FRAC_BITS;
                end
                pwdc_pkg::OP_ADDI: begin
                    n_acc = r_acc + AW'(r_integ);
                end
                pwdc_pkg::OP_DIFF: begin
                    n_acc = AW'(r_last) - AW'(r_meas);
                end
                pwdc_pkg::OP_SUM: begin
                    n_acc = AW'(r_p) + AW'(r_i) + AW'(r_d);
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
            case (ctrl.dst)
                pwdc_pkg::DST_E:     begin n_e     = n_acc[31:0]; end
                pwdc_pkg::DST_INTEG: begin n_integ = n_acc[31:0]; end
                pwdc_pkg::DST_P:     begin n_p     = n_acc[31:0]; end
                pwdc_pkg::DST_I:     begin n_i     = n_acc[31:0]; end
                pwdc_pkg::DST_D:     begin n_d     = n_acc[31:0]; end
                pwdc_pkg::DST_DRIVE: begin n_drv   = n_acc[31:0]; end
                default:             begin n_drv   = r_drv; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_step  <= 17'd66;
            r_dband <= '0;
            r_elim  <= '0;
            r_ilim  <= '0;
            r_olim  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (pwdc_pkg::t_cfg_idx'(i_cfg_index))
                pwdc_pkg::CFG_KP:         begin r_kp    <= i_cfg_data; end
                pwdc_pkg::CFG_KI:         begin r_ki    <= i_cfg_data; end
                pwdc_pkg::CFG_KD_OVER_DT: begin r_kd    <= i_cfg_data; end
                pwdc_pkg::CFG_STEP_TIME:  begin r_step  <= i_cfg_data[16:0]; end
                pwdc_pkg::CFG_DEAD_BAND:  begin r_dband <= i_cfg_data[30:0]; end
                pwdc_pkg::CFG_ERR_LIMIT:  begin r_elim  <= i_cfg_data[30:0]; end
                pwdc_pkg::CFG_INT_LIMIT:  begin r_ilim  <= i_cfg_data[30:0]; end
                pwdc_pkg::CFG_OUT_LIMIT:  begin r_olim  <= i_cfg_data[30:0]; end
                default:                  begin r_olim  <= r_olim; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_e    <= n_e;
        r_p    <= n_p;
        r_i    <= n_i;
        r_d    <= n_d;
        r_drv  <= n_drv;
        if (i_in_valid && o_in_ready) begin
            r_tgt  <= i_target;
            r_meas <= i_measured;
            r_bias <= i_bias;
        end
        if (done) begin
            r_out_drive   <= n_drv;
            r_out_err     <= r_e;
            r_out_clamped <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_flag      <= 1'b0;
            r_integ     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_busy  <= 1'b1;
                r_pc    <= '0;
                r_flag  <= 1'b0;
                r_integ <= i_clear_integral ? 32'sd0 : r_integ;
            end else begin
                r_flag  <= n_flag;
                r_integ <= n_integ;
                if (r_busy) begin
                    if (ctrl.cond == pwdc_pkg::COND_END) begin
                        if (done) begin
                            r_busy <= 1'b0;
                            r_pc   <= '0;
                            r_last <= r_meas;
                        end
                    end else if (skip) begin
                        r_pc <= ctrl.target;
                    end else begin
                        r_pc <= r_pc + PW'(1);
                    end
                end
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
